// ===== src/ssdf_pkg.sv =====
// Shared constants and lookup functions for the seven-segment display formatter.
// No dependencies; imported by seven_segment_display_formatter_top.
`default_nettype none

package ssdf_pkg;

    typedef logic [7:0] t_byte;
    typedef t_byte      t_run [0:5];

    // Command codes
    localparam logic [1:0] FUNC_SHOW_BLANKED = 2'd0;
    localparam logic [1:0] FUNC_SHOW_ZEROS   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR        = 2'd2;
    localparam logic [1:0] FUNC_BRIGHTNESS   = 2'd3;

    localparam logic [6:0]  ADDR_RESET    = 7'd56;
    localparam t_byte       INSTR_DIGITS  = 8'h01;
    localparam t_byte       INSTR_CONTROL = 8'h00;
    localparam t_byte       SEG_BLANK     = 8'h00;
    localparam logic [13:0] MAX_SHOWN     = 14'd9999;
    localparam logic [2:0]  LEVEL_MAX     = 3'd6;
    localparam logic [2:0]  LEN_DIGITS    = 3'd6;
    localparam logic [2:0]  LEN_CONTROL   = 3'd3;

    // Segment pattern, bit 0 = a ... bit 6 = g
    function automatic t_byte seg_pattern(input logic [3:0] digit);
        t_byte pat;
        case (digit)
            4'd0:    pat = 8'd63;
            4'd1:    pat = 8'd6;
            4'd2:    pat = 8'd91;
            4'd3:    pat = 8'd79;
            4'd4:    pat = 8'd102;
            4'd5:    pat = 8'd109;
            4'd6:    pat = 8'd125;
            4'd7:    pat = 8'd7;
            4'd8:    pat = 8'd127;
            4'd9:    pat = 8'd111;
            default: pat = SEG_BLANK;
        endcase
        return pat;
    endfunction

    // Control byte for a segment current level (already clamped)
    function automatic t_byte level_ctrl(input logic [2:0] level);
        t_byte ctrl;
        case (level)
            3'd0:    ctrl = 8'h07;
            3'd1:    ctrl = 8'h17;
            3'd2:    ctrl = 8'h27;
            3'd3:    ctrl = 8'h37;
            3'd4:    ctrl = 8'h47;
            3'd5:    ctrl = 8'h67;
            default: ctrl = 8'h77;
        endcase
        return ctrl;
    endfunction

endpackage

`default_nettype wire

// ===== src/seven_segment_display_formatter_top.sv =====
// Seven-segment display formatter: command beats in, two-wire bus write bytes out.
// Depends on ssdf_pkg (codes, segment and control byte tables).
`default_nettype none

// Usage
//   Command channel (i_valid/o_ready): func, number, brightness_level.
//   Byte channel (o_valid/i_ready): one bus byte per beat, with o_is_address on
//   the first byte of a run and o_last_of_run on its final byte.
//   Config channel (i_cfg_valid/o_cfg_ready): 7-bit device address, always ready;
//   write it only while no run is pending. Reset value is 56.
// Runs: show number and clear give six bytes (address, 0x01, four digits ones
//   first); brightness gives three (address, 0x00, control byte).
// Path: a command's address byte is offered once it has passed S1 to S4 and been loaded into the shifter.
// Throughput: one byte per cycle at the output while i_ready is high. The output
//   shifter is the bottleneck, and four pipeline stages (saturate, thousands,
//   hundreds, tens/segments) ahead of it keep later commands queued up.
// Stalls: when i_ready is low the current byte holds, the shifter holds, and
//   back-pressure ripples stage by stage to o_ready; nothing is dropped or
//   repeated. Synchronous active-low reset empties all stages and restores the
//   address register.
module seven_segment_display_formatter_top
    import ssdf_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_func,
    input  wire logic [13:0] i_number,
    input  wire logic [2:0]  i_brightness_level,
    // config channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [6:0]  i_cfg_data,
    // byte channel
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_bus_byte,
    output logic             o_is_address,
    output logic             o_last_of_run
);

    // ---------------- config register ----------------
    logic [6:0] r_dev_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= ADDR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_dev_addr <= i_cfg_data;
        end
    end

    // ---------------- pipeline registers ----------------
    // S1: saturated number
    logic        r1_v;
    logic [1:0]  r1_func;
    logic [2:0]  r1_lvl;
    logic [13:0] r1_num;
    // S2: thousands digit split off
    logic        r2_v;
    logic [1:0]  r2_func;
    logic [2:0]  r2_lvl;
    logic [3:0]  r2_th;
    logic [9:0]  r2_rem;
    // S3: hundreds digit split off
    logic        r3_v;
    logic [1:0]  r3_func;
    logic [2:0]  r3_lvl;
    logic [3:0]  r3_th;
    logic [3:0]  r3_hu;
    logic [6:0]  r3_rem;
    // S4: run bytes assembled
    logic        r4_v;
    t_run        r4_run;
    logic [2:0]  r4_len;
    // output shifter
    logic        r_busy;
    t_run        r_sh;
    logic [2:0]  r_idx;
    logic [2:0]  r_last_idx;

    logic en1, en2, en3, en4, load, ser_free, out_last;

    // ready ripples back from the shifter
    assign out_last = (r_idx == r_last_idx);
    assign ser_free = !r_busy || (i_ready && out_last);
    assign load     = r4_v && ser_free;
    assign en4      = !r4_v || load;
    assign en3      = !r3_v || en4;
    assign en2      = !r2_v || en3;
    assign en1      = !r1_v || en2;
    assign o_ready  = en1;

    // ---------------- stage logic ----------------
    logic [13:0] n1_num;
    logic [3:0]  n2_th;
    logic [9:0]  n2_rem;
    logic [3:0]  n3_hu;
    logic [6:0]  n3_rem;
    logic [3:0]  n4_te;
    logic [3:0]  n4_on;
    t_run        n4_run;
    logic [2:0]  n4_len;
    logic [2:0]  n4_lvl;
    t_byte       addr_byte;

    assign n1_num = (i_number > MAX_SHOWN) ? MAX_SHOWN : i_number;

    // thousands: nine parallel compares, then one subtract
    always_comb begin
        n2_th = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r1_num >= 14'(k * 1000)) n2_th = 4'(k);
        end
        n2_rem = 10'(r1_num - 14'(14'(n2_th) * 14'd1000));
    end

    // hundreds
    always_comb begin
        n3_hu = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r2_rem >= 10'(k * 100)) n3_hu = 4'(k);
        end
        n3_rem = 7'(r2_rem - 10'(10'(n3_hu) * 10'd100));
    end

    // tens/ones, segment lookup, blanking, run assembly
    assign addr_byte = {r_dev_addr, 1'b0};

    always_comb begin
        n4_te = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r3_rem >= 7'(k * 10)) n4_te = 4'(k);
        end
        n4_on  = 4'(r3_rem - 7'(7'(n4_te) * 7'd10));
        n4_lvl = (r3_lvl > LEVEL_MAX) ? LEVEL_MAX : r3_lvl;

        n4_run[0] = addr_byte;
        n4_run[1] = INSTR_DIGITS;
        n4_run[2] = seg_pattern(n4_on);
        n4_run[3] = seg_pattern(n4_te);
        n4_run[4] = seg_pattern(r3_hu);
        n4_run[5] = seg_pattern(r3_th);
        n4_len    = LEN_DIGITS;

        case (r3_func)
            FUNC_SHOW_BLANKED: begin
                // ones always shows; higher digits blank while all above are zero
                if (r3_th == 4'd0) n4_run[5] = SEG_BLANK;
                if (r3_th == 4'd0 && r3_hu == 4'd0) n4_run[4] = SEG_BLANK;
                if (r3_th == 4'd0 && r3_hu == 4'd0 && n4_te == 4'd0) begin
                    n4_run[3] = SEG_BLANK;
                end
            end
            FUNC_SHOW_ZEROS: begin
            end
            FUNC_CLEAR: begin
                n4_run[2] = SEG_BLANK;
                n4_run[3] = SEG_BLANK;
                n4_run[4] = SEG_BLANK;
                n4_run[5] = SEG_BLANK;
            end
            default: begin
                n4_run[1] = INSTR_CONTROL;
                n4_run[2] = level_ctrl(n4_lvl);
                n4_run[3] = SEG_BLANK;
                n4_run[4] = SEG_BLANK;
                n4_run[5] = SEG_BLANK;
                n4_len    = LEN_CONTROL;
            end
        endcase
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r4_v   <= 1'b0;
            r_busy <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (load) begin
                r_busy <= 1'b1;
            end else if (r_busy && i_ready && out_last) begin
                r_busy <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_func <= i_func;
            r1_lvl  <= i_brightness_level;
            r1_num  <= n1_num;
        end
        if (en2) begin
            r2_func <= r1_func;
            r2_lvl  <= r1_lvl;
            r2_th   <= n2_th;
            r2_rem  <= n2_rem;
        end
        if (en3) begin
            r3_func <= r2_func;
            r3_lvl  <= r2_lvl;
            r3_th   <= r2_th;
            r3_hu   <= n3_hu;
            r3_rem  <= n3_rem;
        end
        if (en4) begin
            r4_run <= n4_run;
            r4_len <= n4_len;
        end
    end

    // output shifter: byte 0 always at the head
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_last_idx <= '0;
        end else if (load) begin
            r_idx      <= '0;
            r_last_idx <= r4_len - 3'd1;
        end else if (r_busy && i_ready && !out_last) begin
            r_idx <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sh <= r4_run;
        end else if (r_busy && i_ready && !out_last) begin
            for (int k = 0; k < 5; k++) begin
                r_sh[k] <= r_sh[k + 1];
            end
        end
    end

    assign o_valid       = r_busy;
    assign o_bus_byte    = r_sh[0];
    assign o_is_address  = (r_idx == 3'd0);
    assign o_last_of_run = out_last;

    // ---------------- assertions ----------------
`ifndef SYNTHESIS
    a_addr_write_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_is_address) |-> (o_bus_byte[0] == 1'b0))
        else $error("address byte carries read bit");

    a_addr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_is_address && o_last_of_run))
        else $error("run shorter than two bytes");

    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_of_run) |=> (o_valid && !o_is_address))
        else $error("run broken before its last byte");

    a_next_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_of_run) |=> (!o_valid || o_is_address))
        else $error("new run does not start with address byte");

    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_last_idx == 3'd2 || r_last_idx == 3'd5))
        else $error("bad run length");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking bench for seven_segment_display_formatter_top: command beats in,
// bus byte beats out, checked against an in-bench predictor. Needs ssdf_pkg.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ssdf_pkg::*;

    // One display command as it sits on the input channel
    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] number;
        logic [2:0]  level;
    } t_display_cmd;

    // One bus byte beat as it should leave the block
    typedef struct packed {
        t_byte bus_byte;
        logic  is_address;
        logic  last_of_run;
    } t_bus_beat;

    // Seven-segment patterns, bit 0 = a ... bit 6 = g, indexed by digit
    localparam logic [0:9][7:0] SEG_OF_DIGIT = {
        8'd63, 8'd6, 8'd91, 8'd79, 8'd102, 8'd109, 8'd125, 8'd7, 8'd127, 8'd111
    };
    // Control byte per segment current level
    localparam logic [0:6][7:0] LEVEL_CODE = {
        8'h07, 8'h17, 8'h27, 8'h37, 8'h47, 8'h67, 8'h77
    };
    localparam int unsigned SHOWN_LIMIT = 9999;
    localparam int          LONG_HOLD   = 300;     // receiver stall, in cycles
    localparam int          RANDOM_PER_PHASE = 70;

    // ---------------------------------------------------------------
    // Clock, reset, DUT ports (all inputs known from time zero)
    // ---------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_func = '0;
    logic [13:0] i_number = '0;
    logic [2:0]  i_brightness_level = '0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_bus_byte;
    logic        o_is_address;
    logic        o_last_of_run;

    always #6 i_clk = ~i_clk;

    seven_segment_display_formatter_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_func             (i_func),
        .i_number           (i_number),
        .i_brightness_level (i_brightness_level),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_data         (i_cfg_data),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_bus_byte         (o_bus_byte),
        .o_is_address       (o_is_address),
        .o_last_of_run      (o_last_of_run)
    );

    // ---------------------------------------------------------------
    // Shared bench state
    // ---------------------------------------------------------------
    t_display_cmd pending_cmds [$];    // commands not yet put on the channel
    t_bus_beat    expected_bytes [$];  // predicted bytes, oldest first
    logic [6:0]   model_addr = ADDR_RESET;
    int           mismatches = 0;

    // Handshake flags captured at the rising edge, read at the falling edge
    logic cmd_taken = 1'b0;
    logic cfg_taken = 1'b0;

    // Idle control, set per phase by the sequencer; 0 means never idle
    int   sender_odds = 0;
    int   receiver_odds = 0;
    logic long_hold_req = 1'b0;

    // ---------------------------------------------------------------
    // Predictor: expected byte run for one accepted command
    // ---------------------------------------------------------------
    function automatic void predict_run(input t_display_cmd cmd);
        t_byte       run_bytes [0:5];
        int unsigned num;
        int          len;
        int          k;
        logic [2:0]  lvl;
        t_bus_beat   beat;
        run_bytes[0] = {model_addr, 1'b0};    // write bit is 0
        if (cmd.func == FUNC_BRIGHTNESS) begin
            lvl = (cmd.level > LEVEL_MAX) ? LEVEL_MAX : cmd.level;
            run_bytes[1] = INSTR_CONTROL;
            run_bytes[2] = LEVEL_CODE[lvl];
            len = 3;
        end else begin
            run_bytes[1] = INSTR_DIGITS;
            len = 6;
            if (cmd.func == FUNC_CLEAR) begin
                for (k = 2; k < 6; k++)
                    run_bytes[k] = SEG_BLANK;
            end else begin
                num = {18'd0, cmd.number};
                if (num > SHOWN_LIMIT)
                    num = SHOWN_LIMIT;
                // ones digit goes out first
                run_bytes[2] = SEG_OF_DIGIT[num % 10];
                run_bytes[3] = SEG_OF_DIGIT[(num / 10) % 10];
                run_bytes[4] = SEG_OF_DIGIT[(num / 100) % 10];
                run_bytes[5] = SEG_OF_DIGIT[num / 1000];
                if (cmd.func == FUNC_SHOW_BLANKED) begin
                    // leading zeros blank, ones digit always shown
                    if (num < 1000)
                        run_bytes[5] = SEG_BLANK;
                    if (num < 100)
                        run_bytes[4] = SEG_BLANK;
                    if (num < 10)
                        run_bytes[3] = SEG_BLANK;
                end
            end
        end
        for (k = 0; k < len; k++) begin
            beat.bus_byte    = run_bytes[k];
            beat.is_address  = (k == 0);
            beat.last_of_run = (k == len - 1);
            expected_bytes.push_back(beat);
        end
    endfunction

    // ---------------------------------------------------------------
    // Command driver: falling edge, fed from pending_cmds
    // ---------------------------------------------------------------
    int send_gap = 0;

    always @(negedge i_clk) begin : drive_cmd
        t_display_cmd nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !cmd_taken) begin
            // beat still on offer: hold valid and payload
        end else if (send_gap != 0) begin
            i_valid  <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_cmds.size() != 0) begin
            if (sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
                // idle burst: this slot plus send_gap more, drawn at random
                i_valid  <= 1'b0;
                send_gap <= $urandom_range(0, 15);
            end else begin
                nxt = pending_cmds.pop_front();
                i_valid            <= 1'b1;
                i_func             <= nxt.func;
                i_number           <= nxt.number;
                i_brightness_level <= nxt.level;
            end
        end else begin
            i_valid <= 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random not-ready bursts, plus one long hold on request
    // ---------------------------------------------------------------
    int   ready_gap = 0;
    int   hold_left = 0;
    logic long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            i_ready        <= 1'b0;
            hold_left      <= LONG_HOLD - 1;
            long_hold_done <= 1'b1;
        end else if (ready_gap != 0) begin
            i_ready   <= 1'b0;
            ready_gap <= ready_gap - 1;
        end else if (receiver_odds != 0 && $urandom_range(1, receiver_odds) == 1) begin
            i_ready   <= 1'b0;
            ready_gap <= $urandom_range(0, 15);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: rising edge. Output beat is checked before a command
    // accepted on the same edge is predicted (latency keeps them apart).
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch
        t_bus_beat want;
        if (!i_rst_n) begin
            cmd_taken  <= 1'b0;
            cfg_taken  <= 1'b0;
            model_addr = ADDR_RESET;
        end else begin
            cmd_taken <= i_valid && o_ready;
            cfg_taken <= i_cfg_valid && o_cfg_ready;
            if (i_cfg_valid && o_cfg_ready)
                model_addr = i_cfg_data;
            if (o_valid && i_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected byte beat: bus_byte %0h", o_bus_byte);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (o_bus_byte !== want.bus_byte) begin
                        $error("bus_byte: expected %0h, actual %0h", want.bus_byte, o_bus_byte);
                        mismatches++;
                    end
                    if (o_is_address !== want.is_address) begin
                        $error("is_address: expected %0b, actual %0b",
                               want.is_address, o_is_address);
                        mismatches++;
                    end
                    if (o_last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last_of_run, o_last_of_run);
                        mismatches++;
                    end
                end
            end
            if (i_valid && o_ready)
                predict_run({i_func, i_number, i_brightness_level});
        end
    end

    // ---------------------------------------------------------------
    // Sequencer helpers. Everything runs 1 ns past the falling edge, when
    // the driver's updates have landed and no rising edge is near.
    // ---------------------------------------------------------------
    task automatic step_time();
        @(negedge i_clk);
        #1;
    endtask

    task automatic queue_cmd(input logic [1:0] func, input logic [13:0] number,
                             input logic [2:0] level);
        t_display_cmd cmd;
        cmd.func   = func;
        cmd.number = number;
        cmd.level  = level;
        pending_cmds.push_back(cmd);
    endtask

    // Random command; numbers lean toward digit-count and saturation edges
    function automatic t_display_cmd random_cmd();
        t_display_cmd cmd;
        cmd.func  = 2'($urandom_range(0, 3));
        cmd.level = 3'($urandom_range(0, 7));
        case ($urandom_range(0, 7))
            0:       cmd.number = 14'($urandom_range(0, 9));
            1:       cmd.number = 14'($urandom_range(10, 99));
            2:       cmd.number = 14'($urandom_range(100, 999));
            3:       cmd.number = 14'($urandom_range(1000, 9999));
            4:       cmd.number = 14'($urandom_range(9990, 10010));
            5:       cmd.number = 14'($urandom_range(10000, 16383));
            default: cmd.number = 14'($urandom_range(0, 16383));
        endcase
        return cmd;
    endfunction

    // Sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        do
            step_time();
        while (pending_cmds.size() != 0 || i_valid || expected_bytes.size() != 0);
    endtask

    // Address write, only ever issued while the block is idle
    task automatic write_address(input logic [6:0] addr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do
            step_time();
        while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [6:0] addr, input int s_odds, input int r_odds);
        int n;
        write_address(addr);
        sender_odds   = s_odds;
        receiver_odds = r_odds;
        for (n = 0; n < RANDOM_PER_PHASE; n++)
            pending_cmds.push_back(random_cmd());
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int n;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        step_time();

        // Directed pass at the reset address: digit-count edges with blanking,
        // zero-filled values, saturation, clear, and every brightness level.
        sender_odds   = 3;
        receiver_odds = 3;
        queue_cmd(FUNC_SHOW_BLANKED, 14'd0,     3'd0);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd5,     3'd7);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd9,     3'd0);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd10,    3'd7);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd99,    3'd0);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd100,   3'd7);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd999,   3'd0);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd1000,  3'd7);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd9999,  3'd0);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd10000, 3'd7);
        queue_cmd(FUNC_SHOW_BLANKED, 14'd16383, 3'd0);
        queue_cmd(FUNC_SHOW_ZEROS,   14'd0,     3'd7);
        queue_cmd(FUNC_SHOW_ZEROS,   14'd7,     3'd0);
        queue_cmd(FUNC_SHOW_ZEROS,   14'd1234,  3'd7);
        queue_cmd(FUNC_SHOW_ZEROS,   14'd16383, 3'd0);
        queue_cmd(FUNC_CLEAR,        14'd16383, 3'd7);
        for (n = 0; n < 8; n++)
            queue_cmd(FUNC_BRIGHTNESS, 14'($urandom_range(0, 16383)), n[2:0]);
        wait_idle();

        // Random phases, each at its own address, idled differently
        run_phase(7'd127, 4, 4);
        run_phase(7'd0, 0, 3);
        run_phase(7'($urandom_range(0, 127)), 3, 0);

        // Receiver stalls for a long stretch while commands keep coming,
        // so the pipeline fills and o_ready drops.
        long_hold_req = 1'b1;
        run_phase(7'($urandom_range(0, 127)), 0, 0);

        run_phase(7'($urandom_range(0, 127)), 2, 2);
        // closing stretch with no idling on either side
        run_phase(7'($urandom_range(0, 127)), 0, 0);

        // Drain: quiet cycles to catch stray beats
        repeat (30) step_time();
        if (expected_bytes.size() != 0) begin
            $error("%0d expected bytes never arrived", expected_bytes.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("seven_segment_display_formatter_top regression: pass");
        end else begin
            $display("seven_segment_display_formatter_top regression: fail");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run
    initial begin
        #(5_000_000);
        $display("seven_segment_display_formatter_top regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== files.f =====
src/ssdf_pkg.sv
src/seven_segment_display_formatter_top.sv
tb/testbench.sv
